// File: design/prcm_pkg.sv
package prcm_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned DEB_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Whole seconds are taken as (x >> 3) / 125, and the divide by 125 is a
	// multiply by a rounded-up reciprocal and a shift, exact for 29-bit values.
	localparam int unsigned DIFF_HI_W = TIME_W - 3;
	localparam int unsigned RECIP_W = 30;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam int unsigned PROD_W = DIFF_HI_W + RECIP_W;
	localparam int unsigned SECS_W = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] SEC_RECIP = 30'd549755814;

	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic ACTIVE_RST = 1'b1;
	localparam logic [TIME_W-1:0] SAVE_IVL_RST = 32'd300000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_ACTIVE   = 2'd1,
		CFG_SAVE_IVL = 2'd2
	} cfg_idx_t;

	// Word handed from the edge/run stage to the seconds stage.
	typedef struct packed {
		logic                 running;
		logic [TIME_W-1:0]    cycles_total;
		logic [TIME_W-1:0]    elapsed_run_ms;
		logic                 started;
		logic                 stopped;
		logic                 save_request;
		logic [DIFF_HI_W-1:0] diff_hi;
	} run_word_t;

	// Word in the seconds stage, after the multiply.
	typedef struct packed {
		logic                 running;
		logic [TIME_W-1:0]    cycles_total;
		logic [TIME_W-1:0]    elapsed_run_ms;
		logic                 started;
		logic                 stopped;
		logic                 save_request;
		logic [SECS_W-1:0]    secs;
	} secs_word_t;

	typedef struct packed {
		logic              running;
		logic [TIME_W-1:0] cycles_total;
		logic [TIME_W-1:0] on_seconds_total;
		logic [TIME_W-1:0] last_run_seconds;
		logic [TIME_W-1:0] elapsed_run_ms;
		logic              started;
		logic              stopped;
		logic              save_request;
	} result_t;

endpackage

// File: design/prcm_if.sv
interface prcm_sample_if;
	logic        valid;
	logic        ready;
	logic        sense_level;
	logic [31:0] now_ms;

	modport source(output valid, output sense_level, output now_ms, input ready);
	modport sink(input valid, input sense_level, input now_ms, output ready);
endinterface

interface prcm_result_if;
	logic        valid;
	logic        ready;
	logic        running;
	logic [31:0] cycles_total;
	logic [31:0] on_seconds_total;
	logic [31:0] last_run_seconds;
	logic [31:0] elapsed_run_ms;
	logic        started;
	logic        stopped;
	logic        save_request;

	modport source(output valid, output running, output cycles_total,
		output on_seconds_total, output last_run_seconds, output elapsed_run_ms,
		output started, output stopped, output save_request, input ready);
	modport sink(input valid, input running, input cycles_total,
		input on_seconds_total, input last_run_seconds, input elapsed_run_ms,
		input started, input stopped, input save_request, output ready);
endinterface

// File: design/prcm_core.sv
module prcm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	prcm_sample_if.sink                         sample,
	input  logic                                cfg_we,
	input  logic [prcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                s2_valid,
	input  logic                                s2_ready,
	output prcm_pkg::run_word_t                 s2_word
);

	logic [prcm_pkg::DEB_W-1:0]  debounce_q;
	logic                        active_level_q;
	logic [prcm_pkg::TIME_W-1:0] save_ivl_q;

	logic                        v_s1;
	logic                        level_s1;
	logic [prcm_pkg::TIME_W-1:0] now_s1;
	logic                        v_s2;

	logic [prcm_pkg::TIME_W-1:0] last_edge_q;
	logic                        accepted_q;
	logic                        run_q;
	logic [prcm_pkg::TIME_W-1:0] start_time_q;
	logic [prcm_pkg::TIME_W-1:0] cycles_q;
	logic [prcm_pkg::TIME_W-1:0] save_mark_q;

	logic                        en_s1;
	logic                        en_s2;
	logic                        fire;
	logic                        active;
	logic                        change;
	logic                        start;
	logic                        stop;
	logic                        run_n;
	logic [prcm_pkg::TIME_W-1:0] start_time_n;
	logic [prcm_pkg::TIME_W-1:0] cycles_n;
	logic [prcm_pkg::TIME_W-1:0] since_edge;
	logic [prcm_pkg::TIME_W-1:0] since_save;
	logic [prcm_pkg::TIME_W-1:0] run_len;
	logic [prcm_pkg::TIME_W-1:0] elapsed_n;
	logic                        save;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= prcm_pkg::DEBOUNCE_RST;
			active_level_q <= prcm_pkg::ACTIVE_RST;
			save_ivl_q <= prcm_pkg::SAVE_IVL_RST;
		end else if (cfg_we) begin
			unique case (prcm_pkg::cfg_idx_t'(cfg_index))
				prcm_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data[prcm_pkg::DEB_W-1:0];
				prcm_pkg::CFG_ACTIVE:   active_level_q <= cfg_data[0];
				prcm_pkg::CFG_SAVE_IVL: save_ivl_q <= cfg_data[prcm_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign en_s2 = !v_s2 || s2_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign fire = v_s1 && en_s2;
	assign sample.ready = en_s1;

	always_comb begin
		active = (level_s1 == active_level_q);
		since_edge = now_s1 - last_edge_q;
		since_save = now_s1 - save_mark_q;
		run_len = now_s1 - start_time_q;
		change = (active != accepted_q) && (since_edge >= {16'd0, debounce_q});
		start = change && active && !run_q;
		stop = change && !active && run_q;
		run_n = start ? 1'b1 : (stop ? 1'b0 : run_q);
		start_time_n = start ? now_s1 : start_time_q;
		cycles_n = cycles_q + {31'd0, start};
		// On a start or while not running the elapsed time is zero; during a run it is the run length.
		elapsed_n = (run_n && !start) ? run_len : '0;
		save = (since_save >= save_ivl_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && en_s1) begin
			level_s1 <= sample.sense_level;
			now_s1 <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			accepted_q <= 1'b0;
			run_q <= 1'b0;
			start_time_q <= '0;
			cycles_q <= '0;
			save_mark_q <= '0;
		end else if (fire) begin
			if (change) begin
				last_edge_q <= now_s1;
				accepted_q <= active;
			end
			run_q <= run_n;
			start_time_q <= start_time_n;
			cycles_q <= cycles_n;
			if (save) begin
				save_mark_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			s2_word.running <= run_n;
			s2_word.cycles_total <= cycles_n;
			s2_word.elapsed_run_ms <= elapsed_n;
			s2_word.started <= start;
			s2_word.stopped <= stop;
			s2_word.save_request <= save;
			s2_word.diff_hi <= run_len[prcm_pkg::TIME_W-1:3];
		end
	end

	assign s2_valid = v_s2;

endmodule

// File: design/prcm_secs.sv
module prcm_secs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s2_valid,
	output logic                 s2_ready,
	input  prcm_pkg::run_word_t  s2_word,
	prcm_result_if.source        result
);

	logic                        v_s3;
	prcm_pkg::secs_word_t        w_s3;
	logic                        out_v_q;
	prcm_pkg::result_t           out_q;

	logic [prcm_pkg::TIME_W-1:0] on_sec_q;
	logic [prcm_pkg::TIME_W-1:0] last_sec_q;

	logic                        en_out;
	logic                        en_s3;
	logic                        fire;
	logic [prcm_pkg::PROD_W-1:0] prod;
	logic [prcm_pkg::TIME_W-1:0] secs;
	logic [prcm_pkg::TIME_W-1:0] on_sec_n;
	logic [prcm_pkg::TIME_W-1:0] last_sec_n;

	assign en_out = !out_v_q || result.ready;
	assign en_s3 = !v_s3 || en_out;
	assign s2_ready = en_s3;
	assign fire = v_s3 && en_out;

	assign prod = prcm_pkg::PROD_W'(s2_word.diff_hi) * prcm_pkg::PROD_W'(prcm_pkg::SEC_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid && en_s3) begin
			w_s3.running <= s2_word.running;
			w_s3.cycles_total <= s2_word.cycles_total;
			w_s3.elapsed_run_ms <= s2_word.elapsed_run_ms;
			w_s3.started <= s2_word.started;
			w_s3.stopped <= s2_word.stopped;
			w_s3.save_request <= s2_word.save_request;
			w_s3.secs <= prod[prcm_pkg::PROD_W-1:prcm_pkg::RECIP_SHIFT];
		end
	end

	always_comb begin
		secs = prcm_pkg::TIME_W'(w_s3.secs);
		on_sec_n = w_s3.stopped ? (on_sec_q + secs) : on_sec_q;
		last_sec_n = w_s3.stopped ? secs : last_sec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_sec_q <= '0;
			last_sec_q <= '0;
		end else if (fire) begin
			on_sec_q <= on_sec_n;
			last_sec_q <= last_sec_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.running <= w_s3.running;
			out_q.cycles_total <= w_s3.cycles_total;
			out_q.on_seconds_total <= on_sec_n;
			out_q.last_run_seconds <= last_sec_n;
			out_q.elapsed_run_ms <= w_s3.elapsed_run_ms;
			out_q.started <= w_s3.started;
			out_q.stopped <= w_s3.stopped;
			out_q.save_request <= w_s3.save_request;
		end
	end

	assign result.valid = out_v_q;
	assign result.running = out_q.running;
	assign result.cycles_total = out_q.cycles_total;
	assign result.on_seconds_total = out_q.on_seconds_total;
	assign result.last_run_seconds = out_q.last_run_seconds;
	assign result.elapsed_run_ms = out_q.elapsed_run_ms;
	assign result.started = out_q.started;
	assign result.stopped = out_q.stopped;
	assign result.save_request = out_q.save_request;

endmodule

// File: design/pump_run_cycle_monitor.sv
// Debounced pump run-cycle monitor.
// Each word on the sample channel carries the raw sense level and a free-running
// millisecond timestamp. Each accepted sample yields exactly one word on the
// result channel: debounced running status, start count, total and last run
// seconds, elapsed time of the current run and the started, stopped and
// save-request pulses.
// The configuration port writes the debounce time, the active level and the save
// interval; write it only while no sample is in flight.
// A sample passes from acceptance to result valid through the input register,
// the edge and run stage, the seconds multiply stage and the output register.
// One sample can be taken every cycle while the result channel is not stalled;
// the run state loop closes within the edge stage.
// A stalled receiver fills the stages one by one; sample.ready falls only when
// all four hold a word. Reset empties the pipeline, clears all counters and
// timestamps and restores the configuration defaults: 50 ms debounce, active
// high, 300000 ms save interval.
module pump_run_cycle_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	prcm_sample_if.sink                     sample,
	prcm_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [prcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prcm_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                s2_valid;
	logic                s2_ready;
	prcm_pkg::run_word_t s2_word;

	prcm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s2_valid  (s2_valid),
		.s2_ready  (s2_ready),
		.s2_word   (s2_word)
	);

	prcm_secs u_secs (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2_word  (s2_word),
		.result   (result)
	);

endmodule

// File: bench/pump_run_cycle_monitor_test.sv
module pump_run_cycle_monitor_test;
	import prcm_pkg::*;

	localparam int unsigned MS_PER_SEC = 1000;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_WORDS = 230;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic WRITE = 1'b1;
	localparam logic TICK = 1'b0;
	localparam result_t NO_PIN = '0;

	typedef struct {
		logic              is_write;
		cfg_idx_t          reg_sel;
		logic [31:0]       value;
		logic              sense;
		logic [31:0]       stamp;
		logic              pinned;
		result_t           want;
	} plan_row_t;

	// Opening sequence: early edge held off, first run, timestamp wrap, polarity
	// flip while running, zero debounce, zero save interval, widest settings.
	plan_row_t plan [28] = '{
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'd0, 1'b1,
			'{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd10, 1'b1,
			'{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd49, 1'b1,
			'{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd50, 1'b1,
			'{1'b1, 32'd1, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd1050, 1'b1,
			'{1'b1, 32'd1, 32'd0, 32'd0, 32'd1000, 1'b0, 1'b0, 1'b0}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'd1080, 1'b1,
			'{1'b0, 32'd1, 32'd1, 32'd1, 32'd0, 1'b0, 1'b1, 1'b0}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd1100, 1'b1,
			'{1'b0, 32'd1, 32'd1, 32'd1, 32'd0, 1'b0, 1'b0, 1'b0}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd300000, 1'b1,
			'{1'b1, 32'd2, 32'd1, 32'd1, 32'd0, 1'b1, 1'b0, 1'b1}},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd5, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd100, 1'b0, NO_PIN},
		'{WRITE, CFG_ACTIVE, 32'd0, 1'b0, 32'd0, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd200, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'd300, 1'b0, NO_PIN},
		'{WRITE, CFG_DEBOUNCE, 32'd0, 1'b0, 32'd0, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd301, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'd301, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd301, 1'b0, NO_PIN},
		'{WRITE, CFG_SAVE_IVL, 32'd0, 1'b0, 32'd0, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'd301, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'd301, 1'b0, NO_PIN},
		'{WRITE, CFG_DEBOUNCE, 32'd65535, 1'b0, 32'd0, 1'b0, NO_PIN},
		'{WRITE, CFG_SAVE_IVL, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd65835, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'd65836, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b0, 32'h7FFF_FFFF, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'h8000_0000, 1'b0, NO_PIN},
		'{TICK, CFG_DEBOUNCE, 32'd0, 1'b1, 32'hFFFF_FFFE, 1'b0, NO_PIN}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	prcm_sample_if smp_ch();
	prcm_result_if res_ch();

	pump_run_cycle_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Meter settings and state as the monitor should hold them.
	logic [DEB_W-1:0]  deb_cfg;
	logic              active_cfg;
	logic [TIME_W-1:0] save_ivl_cfg;
	logic [TIME_W-1:0] edge_ms;
	logic              level_seen;
	logic              in_run;
	logic [TIME_W-1:0] run_begin_ms;
	logic [TIME_W-1:0] starts;
	logic [TIME_W-1:0] on_secs;
	logic [TIME_W-1:0] last_secs;
	logic [TIME_W-1:0] run_ms;
	logic [TIME_W-1:0] save_mark_ms;

	result_t expected_words[$];
	result_t seen_word;
	result_t due_word;
	int mismatches;
	int n_samples;
	int n_results;
	int n_starts;
	int n_stops;
	int n_saves;
	int n_settings;
	int idle_cycles;
	bit calm;
	int gap_pct;

	function automatic result_t track_pump_tick(input logic lvl, input logic [TIME_W-1:0] stamp);
		result_t r;
		logic act;
		logic [TIME_W-1:0] secs;
		r = '0;
		act = (lvl == active_cfg);
		if (act != level_seen && (stamp - edge_ms) >= {16'd0, deb_cfg}) begin
			edge_ms = stamp;
			if (act && !in_run) begin
				in_run = 1'b1;
				run_begin_ms = stamp;
				starts = starts + 1;
				r.started = 1'b1;
			end else if (!act && in_run) begin
				secs = (stamp - run_begin_ms) / MS_PER_SEC;
				in_run = 1'b0;
				last_secs = secs;
				on_secs = on_secs + secs;
				run_ms = '0;
				r.stopped = 1'b1;
			end
			level_seen = act;
		end
		if (in_run)
			run_ms = stamp - run_begin_ms;
		if ((stamp - save_mark_ms) >= save_ivl_cfg) begin
			save_mark_ms = stamp;
			r.save_request = 1'b1;
		end
		r.running = in_run;
		r.cycles_total = starts;
		r.on_seconds_total = on_secs;
		r.last_run_seconds = last_secs;
		r.elapsed_run_ms = run_ms;
		return r;
	endfunction

	task automatic drain();
		@(negedge clk);
		smp_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	// Every sample yields a word, so an empty queue already means nothing is in
	// flight; the extra idle cycles only space out the register writes.
	task automatic settle();
		drain();
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DEBOUNCE: deb_cfg = v[DEB_W-1:0];
			CFG_ACTIVE:   active_cfg = v[0];
			CFG_SAVE_IVL: save_ivl_cfg = v;
			default: ;
		endcase
	endtask

	task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] stamp,
			input logic pinned, input result_t want);
		int gap;
		result_t r;
		gap = 0;
		if ($urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 7);
		repeat (gap) begin
			@(negedge clk);
			smp_ch.valid <= 1'b0;
		end
		@(negedge clk);
		smp_ch.valid <= 1'b1;
		smp_ch.sense_level <= lvl;
		smp_ch.now_ms <= stamp;
		do @(posedge clk); while (smp_ch.ready !== 1'b1);
		r = track_pump_tick(lvl, stamp);
		expected_words.push_back(pinned ? want : r);
		n_samples++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int n;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				res_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 39) == 0) begin
				res_ch.ready <= 1'b1;
				repeat (30) @(negedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			seen_word.running = res_ch.running;
			seen_word.cycles_total = res_ch.cycles_total;
			seen_word.on_seconds_total = res_ch.on_seconds_total;
			seen_word.last_run_seconds = res_ch.last_run_seconds;
			seen_word.elapsed_run_ms = res_ch.elapsed_run_ms;
			seen_word.started = res_ch.started;
			seen_word.stopped = res_ch.stopped;
			seen_word.save_request = res_ch.save_request;
			n_results++;
			n_starts += seen_word.started;
			n_stops += seen_word.stopped;
			n_saves += seen_word.save_request;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Result word %0d arrived with nothing expected", n_results);
			end else begin
				due_word = expected_words.pop_front();
				if (seen_word !== due_word) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("Result word %0d mismatch:", n_results);
						$display("  expected run=%b cyc=%h on=%h last=%h el=%h st=%b sp=%b sv=%b",
							due_word.running, due_word.cycles_total, due_word.on_seconds_total,
							due_word.last_run_seconds, due_word.elapsed_run_ms,
							due_word.started, due_word.stopped, due_word.save_request);
						$display("  actual   run=%b cyc=%h on=%h last=%h el=%h st=%b sp=%b sv=%b",
							seen_word.running, seen_word.cycles_total, seen_word.on_seconds_total,
							seen_word.last_run_seconds, seen_word.elapsed_run_ms,
							seen_word.started, seen_word.stopped, seen_word.save_request);
					end
				end
			end
		end
	end

	initial begin
		int p;
		int i;
		int k;
		int unsigned deb_span;
		logic lvl;
		logic [TIME_W-1:0] stamp;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEBOUNCE;
		cfg_data = '0;
		smp_ch.valid = 1'b0;
		smp_ch.sense_level = 1'b0;
		smp_ch.now_ms = '0;
		calm = 1'b0;
		gap_pct = 25;
		mismatches = 0;
		n_samples = 0;
		n_results = 0;
		n_starts = 0;
		n_stops = 0;
		n_saves = 0;
		n_settings = 1;
		idle_cycles = 0;
		deb_cfg = DEBOUNCE_RST;
		active_cfg = ACTIVE_RST;
		save_ivl_cfg = SAVE_IVL_RST;
		edge_ms = '0;
		level_seen = 1'b0;
		in_run = 1'b0;
		run_begin_ms = '0;
		starts = '0;
		on_secs = '0;
		last_secs = '0;
		run_ms = '0;
		save_mark_ms = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[j]) begin
			if (plan[j].is_write) begin
				settle();
				write_reg(plan[j].reg_sel, plan[j].value);
				n_settings++;
			end else begin
				send_sample(plan[j].sense, plan[j].stamp, plan[j].pinned, plan[j].want);
			end
		end

		for (p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			case (p)
				0: begin
					write_reg(CFG_DEBOUNCE, 32'd0);
					write_reg(CFG_ACTIVE, 32'd1);
					write_reg(CFG_SAVE_IVL, 32'd1);
				end
				1: begin
					// Upper data bits set on the narrow registers must be dropped.
					write_reg(CFG_DEBOUNCE, 32'hFFFF_FFFF);
					write_reg(CFG_ACTIVE, 32'hFFFF_FFFE);
					write_reg(CFG_SAVE_IVL, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(CFG_DEBOUNCE, $urandom_range(0, 300));
					write_reg(CFG_ACTIVE, $urandom_range(0, 1));
					write_reg(CFG_SAVE_IVL, 32'd0);
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						write_reg(CFG_DEBOUNCE, $urandom_range(0, 65535));
					else
						write_reg(CFG_DEBOUNCE, $urandom_range(0, 300));
					write_reg(CFG_ACTIVE, $urandom_range(0, 1));
					write_reg(CFG_SAVE_IVL, $urandom_range(1, 20000));
				end
			endcase
			n_settings++;
			calm = (p == RANDOM_PHASES - 1);
			gap_pct = calm ? 0 : $urandom_range(0, 40);
			deb_span = 2 * deb_cfg + 50;
			lvl = $urandom_range(0, 1);
			stamp = $urandom;
			for (i = 0; i < PHASE_WORDS; i++) begin
				k = $urandom_range(0, 99);
				if (k < 6) begin
					lvl = $urandom_range(0, 1);
					stamp = $urandom;
				end else if (k < 10) begin
					stamp = stamp - $urandom_range(1, 1000);
				end else if (k < 18) begin
					stamp = stamp + $urandom_range(1000, 200000);
				end else begin
					// Mostly steady time steps around the debounce window with a
					// level that bounces now and then.
					stamp = stamp + $urandom_range(0, deb_span);
					if ($urandom_range(0, 2) == 0)
						lvl = ~lvl;
				end
				if (!calm && ((p == 3 && i == PHASE_WORDS / 2) || $urandom_range(0, 299) == 0))
					drain();
				send_sample(lvl, stamp, 1'b0, NO_PIN);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d result words for %0d samples over %0d register settings.",
			n_results, n_samples, n_settings);
		$display("Runs started %0d times and stopped %0d times; %0d save pulses seen.",
			n_starts, n_stops, n_saves);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
